// ===== hdl/skmj_pkg.sv =====
package skmj_pkg;

  localparam int unsigned MaxMarkersDefault = 16384;
  localparam int unsigned MaxRunDefault     = 8;

  localparam int unsigned KmerW  = 32;
  localparam int unsigned FreqW  = 32;
  localparam int unsigned OrdW   = 14;
  localparam int unsigned TotalW = 20;
  localparam int unsigned LocW   = 4;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STREAM = 2'd1,
    FUNC_END    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_MIN_GF    = 2'd0,
    CFG_MAX_GF    = 2'd1,
    CFG_MAX_LOCAL = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // write input marker into the store
    logic run_add;     // append input to the open run
    logic run_start;   // start a new run from the input
    logic in_hold;     // capture the input marker that closes a run
    logic run_restart; // start a new run from the captured marker
    logic walk_start;  // latch walk pointer as run start
    logic walk_rd;     // issue read at walk pointer
    logic walk_adv;    // advance walk pointer
    logic mark_start;  // capture frequency of the read marker at run start
    logic pair_rd;     // read first-read entry i for pairing
    logic emit;        // load output register with a pair
    logic emit_end;    // load output register with bare end marker
    logic job_clear;   // clear job state after end
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic run_open;
    logic run_same;    // input kmer equals open run kmer
    logic ptr_end;     // walk pointer reached fill count
    logic rd_less;     // read kmer < run kmer
    logic rd_equal;    // read kmer == run kmer
    logic pair_ok;     // run lengths and frequency pass
    logic j_last;
    logic i_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== hdl/sorted_kmer_merge_join.sv =====
// Loads and streamed markers that close no run are taken in the idle state without a stall.
// A closing run stalls the input while each stored marker is read and compared, then for
// the run check and restart, for each pair and for each reread of a first-read marker, plus
// output stalls; set by the single read port of the first-read store.
// Results appear in the cycle after issue, from the output register.
// Reset is asynchronous, active low: clears control state, counters and the output valid;
// stores and data registers are not cleared and the fill count governs the stores' use.
module sorted_kmer_merge_join #(
  parameter int unsigned MaxMarkers = skmj_pkg::MaxMarkersDefault,
  parameter int unsigned MaxRun     = skmj_pkg::MaxRunDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [skmj_pkg::KmerW-1:0]  kmer_id_i,
  input  logic [skmj_pkg::FreqW-1:0]  global_frequency_i,
  input  logic [skmj_pkg::OrdW-1:0]   ordinal_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [skmj_pkg::OrdW-1:0]   first_ordinal_o,
  output logic [skmj_pkg::OrdW-1:0]   second_ordinal_o,
  output logic                        pair_valid_o,
  output logic                        last_o,
  output logic [skmj_pkg::TotalW-1:0] total_pairs_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import skmj_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [FreqW-1:0] min_gf_q, max_gf_q;
  logic [LocW-1:0]  max_local_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gf_q    <= '0;
      max_gf_q    <= '1;
      max_local_q <= LocW'(8);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_GF:    min_gf_q    <= cfg_data_i;
        CFG_MAX_GF:    max_gf_q    <= cfg_data_i;
        CFG_MAX_LOCAL: max_local_q <= cfg_data_i[LocW-1:0];
        default: ;
      endcase
    end
  end

  skmj_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  skmj_datapath #(.MaxMarkers(MaxMarkers), .MaxRun(MaxRun)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .kmer_id_i, .global_frequency_i, .ordinal_i,
    .min_gf_i(min_gf_q), .max_gf_i(max_gf_q), .max_local_i(max_local_q),
    .out_stall_i, .out_valid_o, .first_ordinal_o, .second_ordinal_o,
    .pair_valid_o, .last_o, .total_pairs_o
  );

endmodule

// ===== hdl/skmj_datapath.sv =====
module skmj_datapath #(
  parameter int unsigned MaxMarkers = skmj_pkg::MaxMarkersDefault,
  parameter int unsigned MaxRun     = skmj_pkg::MaxRunDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  skmj_pkg::ctl_t              ctl_i,
  output skmj_pkg::sts_t              sts_o,
  input  logic [skmj_pkg::KmerW-1:0]  kmer_id_i,
  input  logic [skmj_pkg::FreqW-1:0]  global_frequency_i,
  input  logic [skmj_pkg::OrdW-1:0]   ordinal_i,
  input  logic [skmj_pkg::FreqW-1:0]  min_gf_i,
  input  logic [skmj_pkg::FreqW-1:0]  max_gf_i,
  input  logic [skmj_pkg::LocW-1:0]   max_local_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [skmj_pkg::OrdW-1:0]   first_ordinal_o,
  output logic [skmj_pkg::OrdW-1:0]   second_ordinal_o,
  output logic                        pair_valid_o,
  output logic                        last_o,
  output logic [skmj_pkg::TotalW-1:0] total_pairs_o
);
  import skmj_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxMarkers);
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned RunW  = (MaxRun > 1) ? $clog2(MaxRun) : 1;
  localparam int unsigned LenW  = $clog2(MaxRun + 2);
  localparam int unsigned InfoW = FreqW + OrdW;

  logic [KmerW-1:0] kmer_mem [MaxMarkers];
  logic [InfoW-1:0] info_mem [MaxMarkers];
  logic [KmerW-1:0] rd_kmer_q;
  logic [InfoW-1:0] rd_info_q;

  logic [CntW-1:0] count_q, ptr_q, start_q;
  logic [OrdW-1:0] run_ord_q [MaxRun];
  logic [KmerW-1:0] run_kmer_q;
  logic [LenW-1:0] run_len_q;
  logic [TotalW-1:0] total_q;
  logic [LenW-1:0] i_q, j_q;
  logic [FreqW-1:0] gf_q;
  logic [KmerW-1:0] hold_kmer_q;
  logic [OrdW-1:0] hold_ord_q;

  logic out_valid_q, pv_q, last_q;
  logic [OrdW-1:0] o0_q, o1_q;
  logic [TotalW-1:0] tot_q;

  logic [CntW-1:0] rd_addr;
  logic [LenW-1:0] limit, local0;
  logic [TotalW-1:0] total_inc;

  always_comb begin
    if (32'(max_local_i) > MaxRun) begin
      limit = LenW'(MaxRun);
    end else begin
      limit = LenW'(max_local_i);
    end
  end

  // clamp long first-read runs; anything above MaxRun fails the limit anyway
  always_comb begin
    if ((ptr_q - start_q) > CntW'(MaxRun + 1)) begin
      local0 = LenW'(MaxRun + 1);
    end else begin
      local0 = LenW'(ptr_q - start_q);
    end
  end

  assign rd_addr   = ctl_i.pair_rd ? (start_q + CntW'(i_q)) : ptr_q;
  assign total_inc = (total_q == TotalMax) ? total_q : total_q + TotalW'(1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && count_q < CntW'(MaxMarkers)) begin
      kmer_mem[count_q[AddrW-1:0]] <= kmer_id_i;
      info_mem[count_q[AddrW-1:0]] <= {global_frequency_i, ordinal_i};
    end
    if (ctl_i.walk_rd || ctl_i.pair_rd) begin
      rd_kmer_q <= kmer_mem[rd_addr[AddrW-1:0]];
      rd_info_q <= info_mem[rd_addr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.run_start) begin
      run_ord_q[0] <= ordinal_i;
    end else if (ctl_i.run_restart) begin
      run_ord_q[0] <= hold_ord_q;
    end else if (ctl_i.run_add && run_len_q < LenW'(MaxRun)) begin
      run_ord_q[run_len_q[RunW-1:0]] <= ordinal_i;
    end
    if (ctl_i.mark_start) begin
      gf_q <= rd_info_q[InfoW-1:OrdW];
    end
    if (ctl_i.in_hold) begin
      hold_kmer_q <= kmer_id_i;
      hold_ord_q  <= ordinal_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ptr_q      <= '0;
      start_q    <= '0;
      run_kmer_q <= '0;
      run_len_q  <= '0;
      total_q    <= '0;
      i_q        <= '0;
      j_q        <= '0;
    end else begin
      if (ctl_i.load && count_q < CntW'(MaxMarkers)) begin
        count_q <= count_q + CntW'(1);
      end
      if (ctl_i.run_start) begin
        run_kmer_q <= kmer_id_i;
        run_len_q  <= LenW'(1);
      end else if (ctl_i.run_restart) begin
        run_kmer_q <= hold_kmer_q;
        run_len_q  <= LenW'(1);
      end else if (ctl_i.run_add && run_len_q <= LenW'(MaxRun)) begin
        run_len_q <= run_len_q + LenW'(1);
      end
      if (ctl_i.walk_adv) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      if (ctl_i.walk_start) begin
        start_q <= ptr_q;
      end
      if (ctl_i.i_clr) begin
        i_q <= '0;
      end else if (ctl_i.i_inc) begin
        i_q <= i_q + LenW'(1);
      end
      if (ctl_i.j_clr) begin
        j_q <= '0;
      end else if (ctl_i.j_inc) begin
        j_q <= j_q + LenW'(1);
      end
      if (ctl_i.emit) begin
        total_q <= total_inc;
      end
      if (ctl_i.job_clear) begin
        count_q    <= '0;
        ptr_q      <= '0;
        run_kmer_q <= '0;
        run_len_q  <= '0;
        total_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit || ctl_i.emit_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      o0_q   <= rd_info_q[OrdW-1:0];
      o1_q   <= run_ord_q[j_q[RunW-1:0]];
      pv_q   <= 1'b1;
      last_q <= (j_q + LenW'(1) == run_len_q) && (i_q + LenW'(1) == local0);
      tot_q  <= total_inc;
    end else if (ctl_i.emit_end) begin
      o0_q   <= '0;
      o1_q   <= '0;
      pv_q   <= 1'b0;
      last_q <= 1'b1;
      tot_q  <= total_q;
    end
  end

  assign sts_o.run_open = run_len_q != '0;
  assign sts_o.run_same = kmer_id_i == run_kmer_q;
  assign sts_o.ptr_end  = ptr_q >= count_q;
  assign sts_o.rd_less  = rd_kmer_q < run_kmer_q;
  assign sts_o.rd_equal = rd_kmer_q == run_kmer_q;
  assign sts_o.pair_ok  = local0 != '0 && local0 <= limit && run_len_q <= limit &&
                          gf_q >= min_gf_i && gf_q <= max_gf_i;
  assign sts_o.j_last   = j_q + LenW'(1) == run_len_q;
  assign sts_o.i_last   = i_q + LenW'(1) == local0;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign first_ordinal_o  = o0_q;
  assign second_ordinal_o = o1_q;
  assign pair_valid_o     = pv_q;
  assign last_o           = last_q;
  assign total_pairs_o    = tot_q;

endmodule

// ===== hdl/skmj_ctrl.sv =====
module skmj_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     func_i,
  input  skmj_pkg::sts_t sts_i,
  output skmj_pkg::ctl_t ctl_o
);
  import skmj_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRD   = 9'b000000010,  // read issued at walk pointer
    S_SKIP  = 9'b000000100,  // compare for less-than walk
    S_MATCH = 9'b000001000,  // read issued for equal walk
    S_CHECK = 9'b000010000,
    S_PRD   = 9'b000100000,  // compare for equal walk
    S_EMIT  = 9'b001000000,
    S_ENDM  = 9'b010000000,
    S_CLR   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic is_end_q, is_end_d, emitted_q, emitted_d;
  logic take;

  assign in_stall_o = state_q != S_IDLE;
  assign take       = in_valid_i && state_q == S_IDLE;

  always_comb begin
    ctl_o     = '0;
    state_d   = state_q;
    is_end_d  = is_end_q;
    emitted_d = emitted_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          case (func_e'(func_i))
            FUNC_LOAD: ctl_o.load = 1'b1;
            FUNC_STREAM: begin
              if (sts_i.run_open && sts_i.run_same) begin
                ctl_o.run_add = 1'b1;
              end else if (sts_i.run_open) begin
                // hold the marker; it opens the next run once this one closes
                ctl_o.in_hold = 1'b1;
                ctl_o.i_clr   = 1'b1;
                ctl_o.j_clr   = 1'b1;
                is_end_d  = 1'b0;
                emitted_d = 1'b0;
                state_d   = S_WRD;
              end else begin
                ctl_o.run_start = 1'b1;
              end
            end
            FUNC_END: begin
              ctl_o.i_clr = 1'b1;
              ctl_o.j_clr = 1'b1;
              is_end_d  = 1'b1;
              emitted_d = 1'b0;
              state_d   = sts_i.run_open ? S_WRD : S_ENDM;
            end
            default: ;
          endcase
        end
      end
      S_WRD: begin
        if (sts_i.ptr_end) begin
          ctl_o.walk_start = 1'b1;
          state_d = S_CHECK;
        end else begin
          ctl_o.walk_rd = 1'b1;
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts_i.rd_less) begin
          ctl_o.walk_adv = 1'b1;
          state_d = S_WRD;
        end else begin
          ctl_o.walk_start = 1'b1;
          ctl_o.mark_start = 1'b1;
          if (sts_i.rd_equal) begin
            ctl_o.walk_adv = 1'b1;
            state_d = S_MATCH;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_MATCH: begin
        // pointer already advanced past one match; read next
        if (sts_i.ptr_end) begin
          state_d = S_CHECK;
        end else begin
          ctl_o.walk_rd = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        if (sts_i.rd_equal) begin
          ctl_o.walk_adv = 1'b1;
          state_d = S_MATCH;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl_o.i_clr = 1'b1;
        ctl_o.j_clr = 1'b1;
        if (sts_i.pair_ok) begin
          ctl_o.pair_rd = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_ENDM;
        end
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          ctl_o.emit = 1'b1;
          emitted_d  = 1'b1;
          if (!sts_i.j_last) begin
            ctl_o.j_inc = 1'b1;
          end else if (!sts_i.i_last) begin
            ctl_o.j_clr = 1'b1;
            ctl_o.i_inc = 1'b1;
            state_d = S_CLR;
          end else begin
            state_d = S_ENDM;
          end
        end
      end
      S_CLR: begin
        ctl_o.pair_rd = 1'b1;
        state_d = S_EMIT;
      end
      S_ENDM: begin
        if (!is_end_q) begin
          ctl_o.run_restart = 1'b1;
          state_d = S_IDLE;
        end else if (emitted_q) begin
          ctl_o.job_clear = 1'b1;
          state_d = S_IDLE;
        end else if (!sts_i.out_busy) begin
          ctl_o.emit_end  = 1'b1;
          ctl_o.job_clear = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      is_end_q  <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_end_q  <= is_end_d;
      emitted_q <= emitted_d;
    end
  end

endmodule
